### rtl/sfd3_pkg.sv
// Shared types and constants for the sum-factorized diagonal block.
package sfd3_pkg;

	localparam int unsigned NCOMP = 3;
	localparam int unsigned VAL_W = 48;

	// Store dimensions; the index ports are three bits wide, so these stay fixed.
	localparam int unsigned MAX_DOFS  = 8;
	localparam int unsigned MAX_QUADS = 8;

	// Item kinds.
	localparam logic [1:0] KIND_BASIS = 2'd0;
	localparam logic [1:0] KIND_HESS  = 2'd1;
	localparam logic [1:0] KIND_COMP  = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	// Configuration register indexes.
	localparam logic REG_DOFS  = 1'b0;
	localparam logic REG_QUADS = 1'b1;

	localparam logic signed [VAL_W-1:0] V48_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] V48_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef logic signed [VAL_W-1:0] val_t;

endpackage

### rtl/sum_factorized_diagonal_3d_core.sv
// Top level of the sum-factorized diagonal block: stores, sequencer and MAC datapath.
//
//  channel  | handshake         | payload
//  in       | in_valid/in_stall | kind comp idx_a idx_b idx_c load_value
//  out      | out_valid/out_stall | value
//  cfg      | cfg_valid/cfg_ready | cfg_index cfg_data
//
// Loads and reads pass through accept, memory access, result register, and the
// cycle in which the result is taken.
// A compute first clears the 1536 result entries, one per cycle, then walks three
// contraction passes per component, of nq*nq*nd, nq*nd*nd and nd^3 output entries,
// on the single MAC unit.
// Reset clears control only; the stores hold garbage until written.
// The block takes one item at a time; a waiting result stalls the input.
module sum_factorized_diagonal_3d_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              kind,
	input  logic [1:0]              comp,
	input  logic [2:0]              idx_a,
	input  logic [2:0]              idx_b,
	input  logic [2:0]              idx_c,
	input  logic signed [31:0]      load_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [47:0]      value,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_index,
	input  logic [3:0]              cfg_data
);
	import sfd3_pkg::*;

	localparam int unsigned DCW = $clog2(MAX_DOFS + 1);
	localparam int unsigned QCW = $clog2(MAX_QUADS + 1);
	localparam int unsigned BD  = MAX_QUADS * MAX_DOFS;
	localparam int unsigned HD  = NCOMP * MAX_QUADS * MAX_QUADS * MAX_QUADS;
	localparam int unsigned QQD = MAX_QUADS * MAX_QUADS * MAX_DOFS;
	localparam int unsigned QDD = MAX_QUADS * MAX_DOFS * MAX_DOFS;
	localparam int unsigned RD  = NCOMP * MAX_DOFS * MAX_DOFS * MAX_DOFS;
	localparam int unsigned BAW = $clog2(BD);
	localparam int unsigned HAW = $clog2(HD);
	localparam int unsigned QQW = $clog2(QQD);
	localparam int unsigned QDW = $clog2(QDD);
	localparam int unsigned RAW = $clog2(RD);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MEM  = 3'd1;
	localparam logic [2:0] ST_MAC  = 3'd2;
	localparam logic [2:0] ST_OUT  = 3'd3;
	localparam logic [2:0] ST_NEXT = 3'd4;

	// Stores.
	logic signed [17:0] basis_mem [BD];
	logic signed [31:0] hess_mem  [HD];
	val_t               qqd_mem   [QQD];
	val_t               qdd_mem   [QDD];
	val_t               res_mem   [RD];

	logic [3:0] dofs_q, quads_q;
	logic [2:0] state_q;
	logic [1:0] kind_q, comp_q, pass_q;
	logic [2:0] a_q, b_q, c_q;
	logic signed [31:0] lv_q;
	logic       out_valid_q;
	val_t       value_q;

	logic [DCW-1:0] nd;
	logic [QCW-1:0] nq;
	assign nd = (dofs_q  > 4'(MAX_DOFS))  ? DCW'(MAX_DOFS)  : DCW'(dofs_q);
	assign nq = (quads_q > 4'(MAX_QUADS)) ? QCW'(MAX_QUADS) : QCW'(quads_q);

	// Compute loop counters: component, pass, output index (i,j,l), summation k.
	logic [1:0] v_q;
	logic [3:0] i_q, j_q, l_q, k_q;
	logic       rd_vld_s1, mul_vld_s2, term_vld_s3;
	logic signed [65:0] acc_q;

	assign in_stall  = (state_q != ST_IDLE) || out_valid_q;
	assign cfg_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign value     = value_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dofs_q  <= 4'd4;
			quads_q <= 4'd4;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DOFS:  dofs_q  <= cfg_data;
				REG_QUADS: quads_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Range checks on the captured indexes.
	logic basis_ok, hess_ok, read_ok;
	assign basis_ok = (32'(a_q) < MAX_QUADS) && (32'(b_q) < MAX_DOFS);
	assign hess_ok  = (comp_q < 2'(NCOMP)) && (32'(a_q) < MAX_QUADS)
	               && (32'(b_q) < MAX_QUADS) && (32'(c_q) < MAX_QUADS);
	assign read_ok  = (comp_q < 2'(NCOMP)) && (32'(a_q) < MAX_DOFS)
	               && (32'(b_q) < MAX_DOFS) && (32'(c_q) < MAX_DOFS);

	logic [BAW-1:0] basis_wa;
	logic [HAW-1:0] hess_wa;
	logic [RAW-1:0] read_a;
	assign basis_wa = BAW'(32'(a_q) * MAX_DOFS + 32'(b_q));
	assign hess_wa  = HAW'(((32'(comp_q) * MAX_QUADS + 32'(a_q)) * MAX_QUADS + 32'(b_q))
	                  * MAX_QUADS + 32'(c_q));
	assign read_a   = RAW'(((32'(comp_q) * MAX_DOFS + 32'(a_q)) * MAX_DOFS + 32'(b_q))
	                  * MAX_DOFS + 32'(c_q));

	logic signed [17:0] lv_sat;
	assign lv_sat = (lv_q > 32'sd131071) ? 18'sd131071 :
	                (lv_q < -32'sd131072) ? -18'sd131072 : 18'(lv_q);

	// Operand addresses for one summation step.
	logic [BAW-1:0] b_ra;
	logic [HAW-1:0] h_ra;
	logic [QQW-1:0] qq_ra, qq_wa;
	logic [QDW-1:0] qd_ra, qd_wa;
	logic [RAW-1:0] r_wa;
	always_comb begin
		unique case (pass_q)
			2'd0:    b_ra = BAW'(32'(k_q) * MAX_DOFS + 32'(l_q));
			2'd1:    b_ra = BAW'(32'(k_q) * MAX_DOFS + 32'(j_q));
			default: b_ra = BAW'(32'(k_q) * MAX_DOFS + 32'(i_q));
		endcase
	end
	assign h_ra  = HAW'(((32'(v_q) * MAX_QUADS + 32'(i_q)) * MAX_QUADS + 32'(j_q))
	               * MAX_QUADS + 32'(k_q));
	assign qq_ra = QQW'((32'(i_q) * MAX_QUADS + 32'(k_q)) * MAX_DOFS + 32'(l_q));
	assign qd_ra = QDW'((32'(k_q) * MAX_DOFS + 32'(j_q)) * MAX_DOFS + 32'(l_q));
	assign qq_wa = QQW'((32'(i_q) * MAX_QUADS + 32'(j_q)) * MAX_DOFS + 32'(l_q));
	assign qd_wa = QDW'((32'(i_q) * MAX_DOFS + 32'(j_q)) * MAX_DOFS + 32'(l_q));
	assign r_wa  = RAW'(((32'(v_q) * MAX_DOFS + 32'(i_q)) * MAX_DOFS + 32'(j_q))
	               * MAX_DOFS + 32'(l_q));

	// Synchronous memory reads, registered.
	logic signed [17:0] b_rd;
	logic signed [31:0] h_rd;
	val_t qq_rd, qd_rd, r_rd;
	logic mac_rd;
	assign mac_rd = (state_q == ST_MAC) && (k_q < 4'(nq));
	always_ff @(posedge clk) begin
		b_rd  <= basis_mem[b_ra];
		h_rd  <= hess_mem[h_ra];
		qq_rd <= qqd_mem[qq_ra];
		qd_rd <= qdd_mem[qd_ra];
		r_rd  <= res_mem[read_a];
	end

	// Stage 2: squared weight and operand select. The weight reaches 2^18.
	logic [18:0] w_s2;
	val_t        x_s2;
	logic signed [35:0] bsq;
	assign bsq = b_rd * b_rd;
	always_ff @(posedge clk) begin
		w_s2 <= 19'(bsq >>> 16);
		unique case (pass_q)
			2'd0:    x_s2 <= VAL_W'(h_rd);
			2'd1:    x_s2 <= qq_rd;
			default: x_s2 <= qd_rd;
		endcase
	end

	// Stage 3: term = floor(w*x / 2^16), split into high and low multiplies.
	logic signed [31:0] xhi;
	logic [15:0]        xlo;
	logic signed [51:0] hi_p_s3;
	logic [34:0]        lo_p_s3;
	assign xhi = 32'(x_s2 >>> 16);
	assign xlo = x_s2[15:0];
	always_ff @(posedge clk) begin
		hi_p_s3 <= xhi * $signed({1'b0, w_s2});
		lo_p_s3 <= xlo * w_s2;
	end

	logic signed [65:0] term;
	assign term = 66'(hi_p_s3) + 66'(signed'({1'b0, lo_p_s3[34:16]}));

	logic signed [65:0] sum_all;
	assign sum_all = acc_q + (term_vld_s3 ? term : 66'sd0);
	val_t sat_sum;
	assign sat_sum = (acc_q > 66'(V48_MAX)) ? V48_MAX :
	                 (acc_q < 66'(V48_MIN)) ? V48_MIN : VAL_W'(acc_q);

	logic [3:0] i_lim, j_lim;
	always_comb begin
		unique case (pass_q)
			2'd0:    begin i_lim = 4'(nq); j_lim = 4'(nq); end
			2'd1:    begin i_lim = 4'(nq); j_lim = 4'(nd); end
			default: begin i_lim = 4'(nd); j_lim = 4'(nd); end
		endcase
	end

	// The entry being finished is the last one of the whole compute.
	logic last_entry;
	assign last_entry = (l_q + 4'd1 >= 4'(nd)) && (j_q + 4'd1 >= j_lim)
	                 && (i_q + 4'd1 >= i_lim) && (pass_q == 2'd2)
	                 && (v_q == 2'(NCOMP - 1));

	// Writes into the stores.
	always_ff @(posedge clk) begin
		if (state_q == ST_MEM && kind_q == KIND_BASIS && basis_ok)
			basis_mem[basis_wa] <= lv_sat;
		if (state_q == ST_MEM && kind_q == KIND_HESS && hess_ok)
			hess_mem[hess_wa] <= lv_q;
		if (state_q == ST_NEXT) begin
			unique case (pass_q)
				2'd0:    qqd_mem[qq_wa] <= sat_sum;
				2'd1:    qdd_mem[qd_wa] <= sat_sum;
				default: res_mem[r_wa]  <= sat_sum;
			endcase
		end
		// All result entries are zeroed by the clearing sweep before the passes start.
		if (state_q == ST_MEM && kind_q == KIND_COMP)
			res_mem[read_a] <= '0;
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			kind_q <= '0; comp_q <= '0; a_q <= '0; b_q <= '0; c_q <= '0;
			v_q <= '0; pass_q <= '0; i_q <= '0; j_q <= '0; l_q <= '0; k_q <= '0;
			rd_vld_s1 <= 1'b0; mul_vld_s2 <= 1'b0; term_vld_s3 <= 1'b0;
			acc_q <= '0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			rd_vld_s1   <= mac_rd;
			mul_vld_s2  <= rd_vld_s1;
			term_vld_s3 <= mul_vld_s2;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !out_valid_q) begin
						kind_q <= kind;
						// A compute request starts its clearing sweep at entry zero.
						if (kind == KIND_COMP) begin
							comp_q <= '0; a_q <= '0; b_q <= '0; c_q <= '0;
						end else begin
							comp_q <= comp; a_q <= idx_a; b_q <= idx_b; c_q <= idx_c;
						end
						state_q <= ST_MEM;
					end
				end
				ST_MEM: begin
					if (kind_q == KIND_COMP) begin
						// Sweep all result entries to zero, one per cycle.
						if ({comp_q, a_q, b_q, c_q} == {2'd2, 3'(MAX_DOFS-1),
						    3'(MAX_DOFS-1), 3'(MAX_DOFS-1)} || !read_ok) begin
							v_q <= '0; pass_q <= '0; i_q <= '0; j_q <= '0;
							l_q <= '0; k_q <= '0; acc_q <= '0;
							state_q <= (nd == '0) ? ST_OUT : ST_MAC;
						end else if (32'(c_q) < MAX_DOFS - 1) c_q <= c_q + 3'd1;
						else begin
							c_q <= '0;
							if (32'(b_q) < MAX_DOFS - 1) b_q <= b_q + 3'd1;
							else begin
								b_q <= '0;
								if (32'(a_q) < MAX_DOFS - 1) a_q <= a_q + 3'd1;
								else begin a_q <= '0; comp_q <= comp_q + 2'd1; end
							end
						end
					end else
						state_q <= ST_OUT;
				end
				ST_MAC: begin
					if (k_q < 4'(nq)) k_q <= k_q + 4'd1;
					if (term_vld_s3) acc_q <= sum_all;
					if (k_q >= 4'(nq) && !rd_vld_s1 && !mul_vld_s2 && !term_vld_s3)
						state_q <= ST_NEXT;
					else if (k_q >= 4'(nq) && !rd_vld_s1 && !mul_vld_s2)
						state_q <= ST_MAC;
				end
				ST_NEXT: begin
					acc_q <= '0; k_q <= '0;
					state_q <= last_entry ? ST_OUT : ST_MAC;
					if (l_q + 4'd1 < 4'(nd)) l_q <= l_q + 4'd1;
					else begin
						l_q <= '0;
						if (j_q + 4'd1 < j_lim) j_q <= j_q + 4'd1;
						else begin
							j_q <= '0;
							if (i_q + 4'd1 < i_lim) i_q <= i_q + 4'd1;
							else begin
								i_q <= '0;
								if (pass_q != 2'd2) pass_q <= pass_q + 2'd1;
								else begin
									pass_q <= '0;
									if (v_q != 2'(NCOMP - 1)) v_q <= v_q + 2'd1;
								end
							end
						end
					end
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register: read data is valid in ST_OUT, the cycle after ST_MEM.
	logic rd_ok_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_MEM) rd_ok_q <= read_ok && (kind_q == KIND_READ);
		if (state_q == ST_OUT) value_q <= rd_ok_q ? r_rd : '0;
		if (state_q == ST_IDLE && in_valid && !out_valid_q) lv_q <= load_value;
	end

endmodule

### rtl/sfd3_checker.sv
// Port-level checker for the sum-factorized diagonal block, with its bind.
module sfd3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [47:0] value,
	input logic        cfg_valid,
	input logic        cfg_ready
);
	// An accepted request yields no result in the very next cycle.
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !out_valid) else $error("early result");

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(value)))
		else $error("result dropped");

	// Configuration is taken only while no request is in flight.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |-> (!in_stall && !out_valid))
		else $error("cfg while busy");

	// No new request is taken while a result waits.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("overlap");
endmodule

bind sum_factorized_diagonal_3d_core sfd3_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .value(value),
	.cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);
